/* rtl/core/wbps_pkg.sv */
`default_nettype none

package wbps_pkg;

  localparam int BYTE_W      = 8;
  localparam int FIELD_ADDR_W = 32;
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 64;
  localparam int MASK_W      = 16;
  localparam int LEN_W       = 5;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PATTERN_LOW  = 8'd0,
    REG_PATTERN_HIGH = 8'd1,
    REG_WILDCARD     = 8'd2,
    REG_LENGTH       = 8'd3
  } wbps_reg_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] pattern_low;
    logic [CFG_DATA_W-1:0] pattern_high;
    logic [MASK_W-1:0]     wildcard_mask;
    logic [LEN_W-1:0]      pattern_length;
  } wbps_cfg_t;

  typedef struct packed {
    logic                    valid;
    logic                    found;
    logic [FIELD_ADDR_W-1:0] address;
  } wbps_result_t;

endpackage

`default_nettype wire

/* rtl/core/wbps_channels.sv */
`default_nettype none

interface wbps_in_if;
  import wbps_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [BYTE_W-1:0]       data_byte;
  logic [FIELD_ADDR_W-1:0] byte_address;
  logic                    region_end;

  modport source (output valid, output data_byte, output byte_address,
                  output region_end, input ready);
  modport sink (input valid, input data_byte, input byte_address,
                input region_end, output ready);
endinterface

interface wbps_out_if;
  import wbps_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    match_found;
  logic [FIELD_ADDR_W-1:0] match_address;

  modport source (output valid, output match_found, output match_address,
                  input ready);
  modport sink (input valid, input match_found, input match_address,
                output ready);
endinterface

interface wbps_cfg_if;
  import wbps_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* rtl/core/wbps_cfg_regs.sv */
`default_nettype none

module wbps_cfg_regs (
  input  wire logic          clk,
  input  wire logic          rst,
  wbps_cfg_if.sink           cfg,
  output wbps_pkg::wbps_cfg_t regs
);
  import wbps_pkg::*;

  wbps_cfg_t regs_next;
  logic      write;

  assign cfg.ready = 1'b1;
  assign write     = cfg.valid && cfg.ready;

  always_comb begin
    regs_next = regs;
    if (write) begin
      unique case (cfg.index)
        REG_PATTERN_LOW:  regs_next.pattern_low    = cfg.data;
        REG_PATTERN_HIGH: regs_next.pattern_high   = cfg.data;
        REG_WILDCARD:     regs_next.wildcard_mask  = cfg.data[MASK_W-1:0];
        REG_LENGTH:       regs_next.pattern_length = cfg.data[LEN_W-1:0];
        default:          regs_next = regs;  // drop writes to unused indexes
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else begin
      regs <= regs_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/wbps_matcher.sv */
`default_nettype none

module wbps_matcher #(
  parameter int PATTERN_MAX   = 16,
  parameter int ADDRESS_WIDTH = 32
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire wbps_pkg::wbps_cfg_t                 regs,
  input  wire logic                                step,
  input  wire logic [wbps_pkg::BYTE_W-1:0]         data_byte,
  input  wire logic [wbps_pkg::FIELD_ADDR_W-1:0]   byte_address,
  input  wire logic                                region_end,
  output wbps_pkg::wbps_result_t                   result
);
  import wbps_pkg::*;

  localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(PATTERN_MAX);

  logic [PATTERN_MAX-1:0]   vec;
  logic                     reported;
  logic [PATTERN_MAX-1:0]   accept;
  logic [PATTERN_MAX:0]     shifted;
  logic [PATTERN_MAX-1:0]   vec_upd;
  logic [LEN_W-1:0]         len_eff;
  logic [LEN_W-1:0]         len_m1;
  logic                     hit;
  logic [ADDRESS_WIDTH-1:0] start;

  // One compare per pattern position
  for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_pos
    if (i < 8) begin : g_low
      assign accept[i] = regs.wildcard_mask[i] ||
                         (regs.pattern_low[8*i +: 8] == data_byte);
    end else begin : g_high
      assign accept[i] = regs.wildcard_mask[i] ||
                         (regs.pattern_high[8*(i-8) +: 8] == data_byte);
    end
  end

  always_comb begin
    len_eff = (regs.pattern_length > LEN_MAX) ? LEN_MAX : regs.pattern_length;
    len_m1  = len_eff - LEN_W'(1);
    shifted = {vec, 1'b1};
    vec_upd = shifted[PATTERN_MAX-1:0] & accept;
    hit     = (len_eff != '0) && vec_upd[len_m1[IDX_W-1:0]];
    start   = ADDRESS_WIDTH'(byte_address) - ADDRESS_WIDTH'(len_m1);

    result.valid   = !reported && (hit || region_end);
    result.found   = hit;
    result.address = hit ? FIELD_ADDR_W'(start) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vec      <= '0;
      reported <= 1'b0;
    end else if (step) begin
      if (region_end) begin
        vec      <= '0;
        reported <= 1'b0;
      end else if (!reported) begin
        vec      <= vec_upd;
        reported <= hit;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/wildcard_byte_pattern_scan.sv */
`default_nettype none

// Wildcard byte-pattern scanner.
// Feed a memory region on byte_stream, one word per byte with its address;
// region_end marks the last byte. Program the pattern through cfg while idle:
// index 0/1 hold pattern bytes 0-7 and 8-15, index 2 the wildcard mask,
// index 3 the length (zero never matches, above PATTERN_MAX is clamped).
// For each region exactly one word leaves on result: the start address of the
// first match as soon as it completes, or match_found low with address zero
// at region end. Bytes after a match give nothing; region end clears state.
// Path: the deciding byte waits in the input register, then its outcome is
// captured in the result register, where result valid rises and the word
// leaves. Throughput: one byte per cycle while no held result is stalled,
// with the shift-and vector updated on each byte that steps the matcher.
// When the receiver stalls, the result register holds and the input register
// takes one more byte; byte_stream.ready then drops until the result leaves.
// Bytes that give no result still pass freely unless the input register
// is blocked behind a held result.
// Reset (rst, synchronous) clears the configuration, the match vector and
// the valid flags of both pipeline registers.
module wildcard_byte_pattern_scan #(
  parameter int PATTERN_MAX   = 16,
  parameter int ADDRESS_WIDTH = 32
) (
  input wire logic clk,
  input wire logic rst,
  wbps_cfg_if.sink cfg,
  wbps_in_if.sink  byte_stream,
  wbps_out_if.source result
);
  import wbps_pkg::*;

  wbps_cfg_t    regs;
  wbps_result_t res;

  // Input register
  logic                    s1_valid;
  logic [BYTE_W-1:0]       s1_data_byte;
  logic [FIELD_ADDR_W-1:0] s1_address;
  logic                    s1_last;

  // Result register
  logic                    o_valid;
  logic                    o_found;
  logic [FIELD_ADDR_W-1:0] o_address;

  logic out_free;
  logic step;
  logic load;

  wbps_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  wbps_matcher #(
    .PATTERN_MAX   (PATTERN_MAX),
    .ADDRESS_WIDTH (ADDRESS_WIDTH)
  ) u_match (
    .clk          (clk),
    .rst          (rst),
    .regs         (regs),
    .step         (step),
    .data_byte    (s1_data_byte),
    .byte_address (s1_address),
    .region_end   (s1_last),
    .result       (res)
  );

  // Advance the held byte only when the result register can take its outcome
  assign out_free          = !o_valid || result.ready;
  assign step              = s1_valid && out_free;
  assign byte_stream.ready = !s1_valid || out_free;
  assign load              = byte_stream.valid && byte_stream.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (load) begin
      s1_valid <= 1'b1;
    end else if (step) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_data_byte <= byte_stream.data_byte;
      s1_address   <= byte_stream.byte_address;
      s1_last      <= byte_stream.region_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (out_free) begin
      o_valid <= step && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && step && res.valid) begin
      o_found   <= res.found;
      o_address <= res.address;
    end
  end

  assign result.valid         = o_valid;
  assign result.match_found   = o_found;
  assign result.match_address = o_address;

endmodule

`default_nettype wire
